// ===== src/pulse_peak_bpm_averager_top_assert.svh =====
// assertion macros used by the pulse peak bpm averager controller
`ifndef PULSE_PEAK_BPM_AVERAGER_TOP_ASSERT_SVH
`define PULSE_PEAK_BPM_AVERAGER_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PPBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define PPBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ppba_pkg.sv =====
// shared constants and control types for the pulse peak bpm averager
`timescale 1ns / 1ps
`default_nettype none

package ppba_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RATE_W   = 8;
  localparam int unsigned MIN_W    = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HYSTERESIS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL_MS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LOW           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_HIGH          = 3'd4;

  // register reset values
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 12'd2450;
  localparam logic [SAMPLE_W-1:0] HYSTERESIS_RST = 12'd100;
  localparam logic [MIN_W-1:0]    MIN_IVL_RST    = 16'd450;
  localparam logic [RATE_W-1:0]   RATE_LOW_RST   = 8'd40;
  localparam logic [RATE_W-1:0]   RATE_HIGH_RST  = 8'd120;

  // ms per minute, numerator of the beat rate
  localparam int unsigned RATE_NUMERATOR = 60000;

  // shared divider width
  localparam int unsigned DIV_W = 16;

  localparam int unsigned HISTORY_DEPTH_DEF = 10;

  // controller to datapath
  typedef struct packed {
    logic load;            // capture an input request
    logic start_rate_div;  // 60000 / interval
    logic store_rate;      // write rate into ring if in bounds
    logic mark_peak;       // record peak time, arm pulse
    logic walk_clear;      // reset sum, count and walk index
    logic walk_step;       // accumulate one ring entry
    logic start_mean_div;  // sum / count
    logic take_mean;       // latch quotient as held rate
    logic emit;            // load output register
    logic release_check;   // disarm on fall below release level
  } ppba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rise;
    logic interval_ok;
    logic interval_small;
    logic div_done;
    logic walk_last;
    logic count_zero;
    logic out_free;
  } ppba_stat_t;

endpackage

`default_nettype wire

// ===== src/ppba_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module ppba_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [ppba_pkg::DIV_W-1:0] dividend,
  input  wire logic [ppba_pkg::DIV_W-1:0] divisor,
  output logic                          done,
  output logic [ppba_pkg::DIV_W-1:0]    quotient
);
  import ppba_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DIV_W:0]   trial;

  // borrow in the top bit means the divisor does not fit
  assign trial = {rem, quotient[DIV_W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(DIV_W);
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[DIV_W]) begin
          rem      <= trial[DIV_W-1:0];
          quotient <= {quotient[DIV_W-2:0], 1'b1};
        end else begin
          rem      <= {rem[DIV_W-2:0], quotient[DIV_W-1]};
          quotient <= {quotient[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ppba_dp.sv =====
// datapath: config registers, peak state, rate ring, walk and output register
`timescale 1ns / 1ps
`default_nettype none

module ppba_dp #(
  parameter int unsigned HISTORY_DEPTH = ppba_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [ppba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ppba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [ppba_pkg::SAMPLE_W-1:0]   sample,
  input  wire logic [ppba_pkg::TIME_W-1:0]     time_ms,
  input  wire logic                            result_stall,
  input  wire ppba_pkg::ppba_cmd_t             cmd,
  output ppba_pkg::ppba_stat_t                 stat,
  output logic                                 result_valid,
  output logic [ppba_pkg::RATE_W-1:0]          beats_per_minute
);
  import ppba_pkg::*;

  localparam int unsigned PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W = RATE_W + CNT_W;

  // configuration
  logic [SAMPLE_W-1:0] peak_threshold;
  logic [SAMPLE_W-1:0] release_hysteresis;
  logic [MIN_W-1:0]    min_interval_ms;
  logic [RATE_W-1:0]   rate_low;
  logic [RATE_W-1:0]   rate_high;

  // captured request
  logic [SAMPLE_W-1:0] sample_r;
  logic [TIME_W-1:0]   time_r;

  // peak and history state
  logic [TIME_W-1:0]   last_peak_time;
  logic                pulse_armed;
  logic [RATE_W-1:0]   rate_history [HISTORY_DEPTH];
  logic [PTR_W-1:0]    history_pointer;
  logic [RATE_W-1:0]   held_rate;

  // walk accumulators
  logic [PTR_W-1:0]    walk_idx;
  logic [SUM_W-1:0]    rate_sum;
  logic [CNT_W-1:0]    rate_count;

  logic [TIME_W-1:0]   interval;
  logic [RATE_W-1:0]   entry;
  logic                in_bounds;
  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quotient;

  assign interval  = time_r - last_peak_time;
  assign entry     = rate_history[walk_idx];
  assign in_bounds = (div_quotient > {{(DIV_W-RATE_W){1'b0}}, rate_low}) &&
                     (div_quotient < {{(DIV_W-RATE_W){1'b0}}, rate_high});

  assign div_start    = cmd.start_rate_div || cmd.start_mean_div;
  assign div_dividend = cmd.start_mean_div ? DIV_W'(rate_sum) : DIV_W'(RATE_NUMERATOR);
  assign div_divisor  = cmd.start_mean_div ? DIV_W'(rate_count) : interval[DIV_W-1:0];

  ppba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    stat.rise           = (sample_r > peak_threshold) && !pulse_armed;
    stat.interval_ok    = interval > {{(TIME_W-MIN_W){1'b0}}, min_interval_ms};
    stat.interval_small = interval <= TIME_W'(RATE_NUMERATOR);
    stat.div_done       = div_done;
    stat.walk_last      = walk_idx == PTR_W'(HISTORY_DEPTH - 1);
    stat.count_zero     = rate_count == '0;
    stat.out_free       = !result_valid || !result_stall;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold     <= THRESHOLD_RST;
      release_hysteresis <= HYSTERESIS_RST;
      min_interval_ms    <= MIN_IVL_RST;
      rate_low           <= RATE_LOW_RST;
      rate_high          <= RATE_HIGH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PEAK_THRESHOLD:     peak_threshold     <= cfg_data[SAMPLE_W-1:0];
        CFG_RELEASE_HYSTERESIS: release_hysteresis <= cfg_data[SAMPLE_W-1:0];
        CFG_MIN_INTERVAL_MS:    min_interval_ms    <= cfg_data[MIN_W-1:0];
        CFG_RATE_LOW:           rate_low           <= cfg_data[RATE_W-1:0];
        CFG_RATE_HIGH:          rate_high          <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // captured payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= sample;
      time_r   <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_peak_time  <= '0;
      pulse_armed     <= 1'b0;
      history_pointer <= '0;
      held_rate       <= '0;
      walk_idx        <= '0;
      rate_sum        <= '0;
      rate_count      <= '0;
      result_valid    <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        rate_history[i] <= '0;
      end
    end else begin
      if (cmd.store_rate && in_bounds) begin
        rate_history[history_pointer] <= div_quotient[RATE_W-1:0];
        if (history_pointer == PTR_W'(HISTORY_DEPTH - 1)) begin
          history_pointer <= '0;
        end else begin
          history_pointer <= history_pointer + PTR_W'(1);
        end
      end
      if (cmd.mark_peak) begin
        last_peak_time <= time_r;
        pulse_armed    <= 1'b1;
      end
      // release level may be negative, then never true
      if (cmd.release_check && pulse_armed &&
          ({1'b0, sample_r} + {1'b0, release_hysteresis} < {1'b0, peak_threshold})) begin
        pulse_armed <= 1'b0;
      end
      if (cmd.walk_clear) begin
        walk_idx   <= '0;
        rate_sum   <= '0;
        rate_count <= '0;
      end else if (cmd.walk_step) begin
        if (entry != '0) begin
          rate_sum   <= rate_sum + SUM_W'(entry);
          rate_count <= rate_count + CNT_W'(1);
        end
        if (!stat.walk_last) begin
          walk_idx <= walk_idx + PTR_W'(1);
        end
      end
      if (cmd.take_mean) begin
        held_rate <= div_quotient[RATE_W-1:0];
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      beats_per_minute <= held_rate;
    end
  end

endmodule

`default_nettype wire

// ===== src/ppba_ctrl.sv =====
// controller state machine sequencing peak check, divisions and ring walk
`timescale 1ns / 1ps
`default_nettype none

`include "pulse_peak_bpm_averager_top_assert.svh"

module ppba_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire ppba_pkg::ppba_stat_t stat,
  output ppba_pkg::ppba_cmd_t       cmd
);
  import ppba_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    CHECK,
    DIV_RATE,
    STORE,
    WALK,
    MEAN,
    DIV_MEAN,
    EMIT,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_stall = state != IDLE;
  assign accept     = item_valid && (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        if (!stat.rise) begin
          cmd.release_check = 1'b1;
          state_next        = IDLE;
        end else if (stat.interval_ok && stat.interval_small) begin
          cmd.start_rate_div = 1'b1;
          state_next         = DIV_RATE;
        end else begin
          // long interval gives rate zero, never stored
          cmd.mark_peak  = stat.interval_ok;
          cmd.walk_clear = 1'b1;
          state_next     = WALK;
        end
      end
      DIV_RATE: begin
        if (stat.div_done) begin
          state_next = STORE;
        end
      end
      STORE: begin
        cmd.store_rate = 1'b1;
        cmd.mark_peak  = 1'b1;
        cmd.walk_clear = 1'b1;
        state_next     = WALK;
      end
      WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_next = MEAN;
        end
      end
      MEAN: begin
        if (stat.count_zero) begin
          state_next = EMIT;
        end else begin
          cmd.start_mean_div = 1'b1;
          state_next         = DIV_MEAN;
        end
      end
      DIV_MEAN: begin
        if (stat.div_done) begin
          cmd.take_mean = 1'b1;
          state_next    = EMIT;
        end
      end
      EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = FINISH;
        end
      end
      FINISH: begin
        cmd.release_check = 1'b1;
        state_next        = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  `PPBA_ASSERT_NEXT(a_accept_to_check, clk, rst, accept, state == CHECK, "request not checked after accept")
  `PPBA_ASSERT_NOW(a_div_done_expected, clk, rst, stat.div_done, (state == DIV_RATE) || (state == DIV_MEAN), "divider finished outside a divide state")
  `PPBA_ASSERT_NEXT(a_emit_waits, clk, rst, (state == EMIT) && !stat.out_free, state == EMIT, "result dropped while output busy")

endmodule

`default_nettype wire

// ===== src/pulse_peak_bpm_averager_top.sv =====
// top level of the pulse peak detector and beat-rate averager
// usage:
//   item channel: sample and time_ms with item_valid / item_stall; a request is taken
//   when item_valid is high and item_stall low. item_stall is low only while idle.
//   result channel: beats_per_minute with result_valid / result_stall; one result per
//   rising edge of the pulse (sample above threshold while not armed), none otherwise.
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high, write only while no request is in flight.
// processing steps:
//   a request with no rise gets the check and the release check only. a rise goes through
//   accept and check, one pass of the shared serial divider (16 quotient bits, then done)
//   for 60000 / interval and a ring update (both skipped if the interval is out of range),
//   a walk of the rate ring at one entry per cycle, a second divider pass for the mean
//   (skipped if no entry is nonzero), then the output register load once that register
//   is free, and the release check. a new request is taken only after the last is done.
// reset (synchronous, active high): config registers go to their defaults, the ring
//   and peak state clear, no result is pending.
// stalls: the result sits in an output register while result_stall is high; the next
//   request is still taken, and its own result waits until that register frees up.
`timescale 1ns / 1ps
`default_nettype none

module pulse_peak_bpm_averager_top #(
  parameter int unsigned HISTORY_DEPTH = ppba_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // config channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ppba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ppba_pkg::CFG_DATA_W-1:0] cfg_data,
  // item channel
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire logic [ppba_pkg::SAMPLE_W-1:0]   sample,
  input  wire logic [ppba_pkg::TIME_W-1:0]     time_ms,
  // result channel
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic [ppba_pkg::RATE_W-1:0]          beats_per_minute
);
  import ppba_pkg::*;

  ppba_cmd_t  cmd;
  ppba_stat_t stat;

  // the user must write only while idle, the block does not enforce it; no backpressure on config
  assign cfg_ready = 1'b1;

  // sequencing: accept, rate divide, ring update, ring walk, mean divide, emit
  ppba_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // registers, ring, shared divider and output register
  ppba_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .sample           (sample),
    .time_ms          (time_ms),
    .result_stall     (result_stall),
    .cmd              (cmd),
    .stat             (stat),
    .result_valid     (result_valid),
    .beats_per_minute (beats_per_minute)
  );

endmodule

`default_nettype wire
